[hdl/ptoa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptoa_pkg: shared definitions for the packet time-on-air core
// Register indexes, field widths and the small reciprocal table used for the
// payload symbol ceiling.
// ----------------------------------------------------------------------------
package ptoa_pkg;

	localparam int SfW      = 4;
	localparam int BwW      = 19;
	localparam int CrW      = 4;
	localparam int PreW     = 16;
	localparam int LenW     = 8;
	localparam int AirW     = 26;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 19;
	localparam int RecipK   = 15;
	localparam int QuartW   = 20;
	localparam int NumW     = 43;

	localparam logic [AirW-1:0] AirMax = {AirW{1'b1}};

	typedef enum logic [CfgIdxW-1:0] {
		CFG_SF  = 2'd0,
		CFG_BW  = 2'd1,
		CFG_CR  = 2'd2,
		CFG_PRE = 2'd3
	} cfg_idx_t;

	// Rounded-up reciprocal 2^15/d; exact floor division for dividends below 2^11.
	function automatic logic [15:0] recip(input logic [3:0] d);
		logic [15:0] r;
		case (d)
			4'd1:    r = 16'd32768;
			4'd2:    r = 16'd16384;
			4'd3:    r = 16'd10923;
			4'd4:    r = 16'd8192;
			4'd5:    r = 16'd6554;
			4'd6:    r = 16'd5462;
			4'd7:    r = 16'd4682;
			4'd8:    r = 16'd4096;
			4'd9:    r = 16'd3641;
			4'd10:   r = 16'd3277;
			4'd11:   r = 16'd2979;
			4'd12:   r = 16'd2731;
			4'd13:   r = 16'd2521;
			4'd14:   r = 16'd2341;
			4'd15:   r = 16'd2185;
			default: r = 16'd32768;
		endcase
		return r;
	endfunction

endpackage

[hdl/packet_time_on_air_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_time_on_air_core: chirp-spread-spectrum packet time on air
// Computes whole-millisecond airtime and the low-data-rate flag per packet.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel carries one packet length and
// yields exactly one result (airtime_ms, low_rate_mode) on the output channel,
// in order. Both channels use valid/stall handshakes.
// The pipeline has five arithmetic stages, one divider entry stage and
// 26 divider stages, one quotient bit per stage of the restoring divider.
// Throughput is one request per cycle; a new length may enter when unstalled.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
// Reset clears all valid bits and loads the default configuration:
// spreading factor 12, 125000 Hz, coding denominator 8, 8 preamble symbols.
// Configuration is written through cfg_write/cfg_index/cfg_data and must only
// change while no request is in flight.
// ----------------------------------------------------------------------------
module packet_time_on_air_core
	import ptoa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [LenW-1:0]     packet_length,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [AirW-1:0]     airtime_ms,
	output logic                low_rate_mode
);

	logic [SfW-1:0]  sf_q;
	logic [BwW-1:0]  bw_q;
	logic [CrW-1:0]  cr_q;
	logic [PreW-1:0] pre_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q  <= SfW'(12);
			bw_q  <= BwW'(125000);
			cr_q  <= CrW'(8);
			pre_q <= PreW'(8);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SF:  sf_q  <= cfg_data[SfW-1:0];
				CFG_BW:  bw_q  <= cfg_data[BwW-1:0];
				CFG_CR:  cr_q  <= cfg_data[CrW-1:0];
				CFG_PRE: pre_q <= cfg_data[PreW-1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic div_valid;
	assign adv      = !(div_valid && out_stall);
	assign in_stall = !adv;

	// Low-data-rate flag: 1000*2^sf > 16*bw reduces to 125*2^sf > 2*bw.
	logic       ldr;
	logic [21:0] chips125;
	assign chips125 = 22'd125 << sf_q;
	assign ldr      = chips125 > {2'b0, bw_q, 1'b0};

	// Stage 1: clamped quarter numerator plus divisor minus one.
	logic signed [4:0]  d_raw;
	logic        [3:0]  d_c;
	logic signed [11:0] m_raw;
	logic        [9:0]  n_c;
	assign d_raw = $signed({1'b0, sf_q}) - $signed({3'b0, ldr, 1'b0});
	assign d_c   = (d_raw < 5'sd1) ? 4'd1 : d_raw[3:0];
	assign m_raw = $signed({3'b0, packet_length, 1'b0}) + 12'sd6
		- $signed({8'b0, sf_q});
	assign n_c   = (m_raw < 12'sd0) ? 10'(d_c - 4'd1)
		: 10'(m_raw[9:0] + {6'b0, d_c} - 10'd1);

	logic       v_s1, v_s2, v_s3, v_s4, v_s5;
	logic       ldr_s1, ldr_s2, ldr_s3, ldr_s4, ldr_s5;
	logic [9:0] n_s1;
	logic [3:0] d_s1;
	logic [25:0] prod_s2;
	logic [QuartW-1:0] quart_s3;
	logic [QuartW+7:0] scaled_s4;
	logic [NumW-1:0]   num_s5;

	// Stage 3 combinational: payload symbols and total quarter symbols.
	logic [10:0] q_c;
	logic [15:0] pay_c;
	assign q_c   = prod_s2[25:RecipK];
	assign pay_c = 16'd8 + {5'b0, q_c} * {12'b0, cr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Arithmetic stages ahead of the divider.
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1      <= n_c;
			d_s1      <= d_c;
			ldr_s1    <= ldr;
			prod_s2   <= n_s1 * recip(d_s1);
			ldr_s2    <= ldr_s1;
			quart_s3  <= {2'b0, pre_q, 2'b0} + QuartW'(17) + {2'b0, pay_c, 2'b0};
			ldr_s3    <= ldr_s2;
			scaled_s4 <= quart_s3 * 8'd250;
			ldr_s4    <= ldr_s3;
			num_s5    <= {{(NumW-QuartW-8){1'b0}}, scaled_s4} << sf_q;
			ldr_s5    <= ldr_s4;
		end
	end

	ptoa_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.num_valid  (v_s5),
		.num        (num_s5),
		.den        (bw_q),
		.tag        (ldr_s5),
		.quot_valid (div_valid),
		.quot       (airtime_ms),
		.quot_tag   (low_rate_mode)
	);

	assign out_valid = div_valid;

	// Checks.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not caused by output stall");

	a_zero_bw_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bw_q == '0) |-> (airtime_ms == AirMax && low_rate_mode))
		else $error("zero bandwidth did not saturate");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(airtime_ms)))
		else $error("stalled result changed");

	a_ldr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $stable(sf_q) && $stable(bw_q)) |-> (low_rate_mode == ldr))
		else $error("low rate flag mismatch");

endmodule

[hdl/ptoa_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptoa_div: pipelined restoring divider with saturation
// One quotient bit per stage; results that do not fit the output saturate.
// ----------------------------------------------------------------------------
module ptoa_div
	import ptoa_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            num_valid,
	input  logic [NumW-1:0] num,
	input  logic [BwW-1:0]  den,
	input  logic            tag,
	output logic            quot_valid,
	output logic [AirW-1:0] quot,
	output logic            quot_tag
);

	logic            vld_s [0:AirW];
	logic            sat_s [0:AirW];
	logic            tag_s [0:AirW];
	logic [BwW-1:0]  rem_s [0:AirW];
	logic [AirW-1:0] low_s [0:AirW];
	logic [AirW-1:0] quo_s [0:AirW];

	logic [NumW-AirW-1:0] num_hi;
	assign num_hi = num[NumW-1:AirW];

	// Entry stage: overflow check and initial remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= num_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s[0] <= ({2'b0, den} <= {{(BwW+2-(NumW-AirW)){1'b0}}, num_hi});
			rem_s[0] <= {{(BwW-(NumW-AirW)){1'b0}}, num_hi};
			low_s[0] <= num[AirW-1:0];
			quo_s[0] <= '0;
			tag_s[0] <= tag;
		end
	end

	// One quotient bit per stage.
	for (genvar k = 0; k < AirW; k++) begin : g_step
		logic [BwW:0] r2;
		logic         ge;
		assign r2 = {rem_s[k], low_s[k][AirW-1]};
		assign ge = (r2 >= {1'b0, den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? BwW'(r2 - {1'b0, den}) : r2[BwW-1:0];
				low_s[k+1] <= {low_s[k][AirW-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][AirW-2:0], ge};
				sat_s[k+1] <= sat_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign quot_valid = vld_s[AirW];
	assign quot       = sat_s[AirW] ? AirMax : quo_s[AirW];
	assign quot_tag   = tag_s[AirW];

endmodule
